@@ sv/mhc_pkg.sv @@
// Shared types and constants for the packed module header checker.
package mhc_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [6:0]  position_index;
        logic [6:0]  pattern_number;
        logic        accepted;
        logic [3:0]  reject_reason;
        logic [21:0] unpacked_size;
        logic        last;
    } t_out;

    // one stored position: offset and its pattern number
    typedef struct packed {
        logic        valid;
        logic [15:0] offset;
        logic [6:0]  number;
    } t_entry;

    localparam logic        KIND_POSITION = 1'b0;
    localparam logic        KIND_VERDICT  = 1'b1;

    localparam logic [3:0]  RSN_NONE      = 4'd0;
    localparam logic [3:0]  RSN_ID        = 4'd1;
    localparam logic [3:0]  RSN_LENGTH    = 4'd2;
    localparam logic [3:0]  RSN_TOO_BIG   = 4'd3;
    localparam logic [3:0]  RSN_SAMPLE    = 4'd4;
    localparam logic [3:0]  RSN_REPLEN    = 4'd5;
    localparam logic [3:0]  RSN_VOLUME    = 4'd6;
    localparam logic [3:0]  RSN_POS_COUNT = 4'd7;
    localparam logic [3:0]  RSN_PATTERNS  = 4'd8;

    localparam logic [31:0] ID_WORD       = 32'h4D45_5858;
    localparam logic [15:0] VOLUME_LIMIT  = 16'h0040;
    localparam logic [15:0] REPLEN_EMPTY  = 16'h0001;
    localparam logic [24:0] BASE_SIZE     = 25'd1084;
    localparam logic [24:0] SIZE_LIMIT    = 25'd4194303;
    localparam logic [32:0] LENGTH_SLACK  = 33'd256;
    localparam logic [9:0]  ID_END        = 10'd3;
    localparam logic [9:0]  LENGTH_END    = 10'd7;
    localparam logic [9:0]  SAMPLE_PTR_END = 10'h01f;
    localparam logic [9:0]  SAMPLES_AT    = 10'h020;
    localparam logic [9:0]  POS_COUNT_AT  = 10'h118;
    localparam logic [9:0]  POS_COUNT_END = 10'h119;
    localparam logic [9:0]  POS_TABLE_AT  = 10'h11c;

endpackage

@@ sv/mhc_cell.sv @@
// One cell of the position chain: holds an entry and matches it against the key.
module mhc_cell
    import mhc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_clear,
    input  logic        i_push,
    input  t_entry      i_entry,
    input  logic [15:0] i_key,
    output t_entry      o_entry,
    output logic        o_match
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_entry.valid <= 1'b0;
        end else if (i_push) begin
            r_entry.valid <= i_entry.valid;
        end
        if (i_push) begin
            r_entry.offset <= i_entry.offset;
            r_entry.number <= i_entry.number;
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_entry.valid && (r_entry.offset == i_key);

endmodule

@@ sv/mhc_chain.sv @@
// Shift chain of position cells; all cells compare the key at once.
module mhc_chain
    import mhc_pkg::*;
#(
    parameter int CELLS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_clear,
    input  logic        i_push,
    input  t_entry      i_entry,
    input  logic [15:0] i_key,
    output logic        o_found,
    output logic [6:0]  o_number
);

    t_entry     w_link [CELLS+1];
    logic [CELLS-1:0] w_match;

    assign w_link[0] = i_entry;

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        mhc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (i_clear),
            .i_push  (i_push),
            .i_entry (w_link[g]),
            .i_key   (i_key),
            .o_entry (w_link[g+1]),
            .o_match (w_match[g])
        );
    end

    // equal offsets always carry the same number, so an OR picks it
    always_comb begin
        o_number = '0;
        for (int k = 0; k < CELLS; k++) begin
            if (w_match[k]) o_number = o_number | w_link[k+1].number;
        end
    end

    assign o_found = |w_match;

endmodule

@@ sv/packed_module_header_checker_top.sv @@
// Top level: byte parser, header checks, position chain and result buffer.
// Each accepted byte is parsed in its accept cycle; its results (zero to two)
// sit in an output buffer, and the next byte is taken once the buffer drains.
// Pattern lookup compares against every chain cell in parallel in the accept cycle.
// Synchronous active-low reset; after reset the parser idles until a first byte.
module packed_module_header_checker_top
    import mhc_pkg::*;
#(
    parameter int MAX_POSITIONS  = 128,
    parameter int MAX_PATTERNS   = 64,
    parameter int SAMPLE_ENTRIES = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out
);

    logic [31:0] r_file_length;
    logic [9:0]  r_bpos;
    logic [31:0] r_fs;
    logic [15:0] r_size;
    logic [15:0] r_vol;
    logic [22:0] r_total;
    logic [7:0]  r_pcount;
    logic [7:0]  r_cursor;
    logic [7:0]  r_pcnt;
    logic        r_done;
    logic [1:0]  r_cnt;
    t_out        r_res0, r_res1;

    logic [9:0]  n_bpos;
    logic [31:0] n_fs;
    logic [15:0] n_size, n_vol;
    logic [22:0] n_total;
    logic [7:0]  n_pcount, n_cursor, n_pcnt;
    logic        n_done;
    logic [1:0]  n_cnt;
    t_out        n_res0, n_res1;
    logic        w_push;
    t_entry      w_entry;

    logic        w_acc, w_out_acc;
    logic        w_found;
    logic [6:0]  w_fnum;
    logic [9:0]  w_p;
    logic [31:0] w_fs_old;
    logic [4:0]  w_e;
    logic [16:0] w_count;
    logic [8:0]  w_patts;
    logic [24:0] w_size;

    assign w_acc     = i_in_valid && !o_in_stall;
    assign w_out_acc = o_out_valid && !i_out_stall;
    assign o_in_stall  = (r_cnt != 2'd0);
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out       = r_res0;

    // key is the offset word ending with this byte; a first byte never pushes
    mhc_chain #(.CELLS(MAX_POSITIONS)) u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_acc && i_in.first),
        .i_push   (w_push),
        .i_entry  (w_entry),
        .i_key    ({r_fs[7:0], i_in.data_byte}),
        .o_found  (w_found),
        .o_number (w_fnum)
    );

    function automatic t_out f_verdict(input logic acc, input logic [3:0] rsn,
                                       input logic [21:0] size);
        t_out r;
        r = '0;
        r.kind          = KIND_VERDICT;
        r.accepted      = acc;
        r.reject_reason = rsn;
        r.unpacked_size = size;
        r.last          = 1'b1;
        return r;
    endfunction

    always_comb begin
        n_bpos   = r_bpos;
        n_fs     = r_fs;
        n_size   = r_size;
        n_vol    = r_vol;
        n_total  = r_total;
        n_pcount = r_pcount;
        n_cursor = r_cursor;
        n_pcnt   = r_pcnt;
        n_done   = r_done;
        n_cnt    = r_cnt;
        n_res0   = r_res0;
        n_res1   = r_res1;
        w_push   = 1'b0;
        w_entry  = '0;
        w_fs_old = r_fs;
        w_p      = r_bpos;
        w_e      = 5'(w_p - SAMPLES_AT >> 3);
        w_count  = '0;
        w_patts  = '0;
        w_size   = '0;

        if (w_out_acc) begin
            n_res0 = r_res1;
            n_cnt  = r_cnt - 2'd1;
        end

        if (w_acc) begin
            if (i_in.first) begin
                n_bpos = '0; w_fs_old = '0; n_size = '0; n_vol = '0; n_total = '0;
                n_pcount = '0; n_cursor = '0; n_pcnt = '0; n_done = 1'b0;
                w_p = '0;
            end
            n_fs = {w_fs_old[23:0], i_in.data_byte};
            w_e  = 5'((w_p - SAMPLES_AT) >> 3);
            if (!(r_done && !i_in.first)) begin
                n_bpos = w_p + 10'd1;
                if (w_p == ID_END) begin
                    if (n_fs != ID_WORD) begin
                        n_res0 = f_verdict(1'b0, RSN_ID, '0); n_cnt = 2'd1; n_done = 1'b1;
                    end
                end else if (w_p == LENGTH_END) begin
                    if (n_fs == '0 || n_fs[0]) begin
                        n_res0 = f_verdict(1'b0, RSN_LENGTH, '0); n_cnt = 2'd1;
                        n_done = 1'b1;
                    end else if ({1'b0, n_fs} > {1'b0, r_file_length} + LENGTH_SLACK) begin
                        n_res0 = f_verdict(1'b0, RSN_TOO_BIG, '0); n_cnt = 2'd1;
                        n_done = 1'b1;
                    end
                end else if (w_p == SAMPLE_PTR_END) begin
                    if (n_fs == '0 || n_fs[0]) begin
                        n_res0 = f_verdict(1'b0, RSN_SAMPLE, '0); n_cnt = 2'd1;
                        n_done = 1'b1;
                    end
                end else if (w_p >= SAMPLES_AT && w_p < POS_COUNT_AT) begin
                    if (w_p[2:0] == 3'd1) begin
                        n_vol = n_fs[15:0];
                    end else if (w_p[2:0] == 3'd3) begin
                        n_size = n_fs[15:0];
                    end else if (w_p[2:0] == 3'd7 && 32'(w_e) < SAMPLE_ENTRIES) begin
                        if (r_size == '0) begin
                            if (n_fs[15:0] != REPLEN_EMPTY) begin
                                n_res0 = f_verdict(1'b0, RSN_REPLEN, '0); n_cnt = 2'd1;
                                n_done = 1'b1;
                            end
                        end else if (r_vol > VOLUME_LIMIT) begin
                            n_res0 = f_verdict(1'b0, RSN_VOLUME, '0); n_cnt = 2'd1;
                            n_done = 1'b1;
                        end else begin
                            n_total = r_total + {6'd0, r_size, 1'b0};
                        end
                    end
                end else if (w_p == POS_COUNT_END) begin
                    w_count = {1'b0, n_fs[15:0]} + 17'd1;
                    if (32'(w_count) > MAX_POSITIONS) begin
                        n_res0 = f_verdict(1'b0, RSN_POS_COUNT, '0); n_cnt = 2'd1;
                        n_done = 1'b1;
                    end else begin
                        n_pcount = w_count[7:0];
                    end
                end else if (w_p >= POS_TABLE_AT && w_p[1:0] == 2'd1) begin
                    w_entry.valid  = 1'b1;
                    w_entry.offset = n_fs[15:0];
                    w_entry.number = '0;
                    if (r_cursor[6:0] != '0) begin
                        if (w_found) begin
                            w_entry.number = w_fnum;
                        end else begin
                            n_pcnt = r_pcnt + 8'd1;
                            w_entry.number = n_pcnt[6:0];
                        end
                    end
                    w_push   = 1'b1;
                    n_cursor = r_cursor + 8'd1;
                    n_res0 = '0;
                    n_res0.kind           = KIND_POSITION;
                    n_res0.position_index = r_cursor[6:0];
                    n_res0.pattern_number = w_entry.number;
                    n_res0.last           = !(n_cursor >= r_pcount);
                    n_cnt = 2'd1;
                    if (n_cursor >= r_pcount) begin
                        n_cnt   = 2'd2;
                        n_done  = 1'b1;
                        w_patts = {1'b0, n_pcnt} + 9'd1;
                        w_size  = {6'd0, w_patts, 10'd0} + {2'd0, r_total} + BASE_SIZE;
                        if (w_size > SIZE_LIMIT) w_size = SIZE_LIMIT;
                        if (32'(w_patts) > MAX_PATTERNS) begin
                            n_res1 = f_verdict(1'b0, RSN_PATTERNS, '0);
                        end else begin
                            n_res1 = f_verdict(1'b1, RSN_NONE, w_size[21:0]);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_length <= '0;
            r_bpos   <= '0;
            r_fs     <= '0;
            r_size   <= '0;
            r_vol    <= '0;
            r_total  <= '0;
            r_pcount <= '0;
            r_cursor <= '0;
            r_pcnt   <= '0;
            r_done   <= 1'b1;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_we) r_file_length <= i_cfg_data;
            r_bpos   <= n_bpos;
            r_fs     <= n_fs;
            r_size   <= n_size;
            r_vol    <= n_vol;
            r_total  <= n_total;
            r_pcount <= n_pcount;
            r_cursor <= n_cursor;
            r_pcnt   <= n_pcnt;
            r_done   <= n_done;
            r_cnt    <= n_cnt;
        end
        r_res0 <= n_res0;
        r_res1 <= n_res1;
    end

    // a verdict is always the final result of its byte
    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.kind |-> o_out.last)
        else $error("verdict without last");

    // a buffered pair always starts with a non-final position entry
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !r_res0.last && r_res0.kind == KIND_POSITION)
        else $error("bad result pair");

    // a first byte always starts a parse
    a_first_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_in.first |=> !r_done)
        else $error("first byte did not start parse");

    // the cursor never runs past the position count while parsing
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_done && r_pcount != '0 |-> r_cursor < r_pcount)
        else $error("cursor past count");

endmodule

@@ tb/sv/packed_module_header_checker_top_tb.sv @@
// Testbench for the packed module header checker: random and directed modules, scoreboarded.
module packed_module_header_checker_top_tb;
    import mhc_pkg::*;

    localparam int N_POS_MAX  = 128;
    localparam int N_PAT_MAX  = 64;
    localparam int N_SAMPLES  = 31;
    localparam int WATCHDOG   = 20000;

    // header layout offsets used when building modules
    localparam int SAMPLE_PTR_BYTE = 'h1c;
    localparam int SAMPLE_BYTE     = 'h20;
    localparam int COUNT_BYTE      = 'h118;
    localparam int TABLE_BYTE      = 'h11c;

    // kinds of broken modules
    typedef enum int {
        BRK_NONE, BRK_ID, BRK_LEN_ODD, BRK_LEN_ZERO, BRK_LEN_BIG, BRK_SPTR,
        BRK_REPLEN, BRK_VOLUME, BRK_COUNT, BRK_COUNT_FFFF, BRK_PATTERNS, BRK_TRUNC,
        BRK_LAST
    } t_break;

    class header_scoreboard;
        logic [31:0] file_len;
        logic [9:0]  pos;
        logic [31:0] shreg;
        logic [15:0] size_w, vol_w;
        logic [22:0] sample_sum;
        logic [7:0]  pcount, pcursor, pcounter;
        logic [15:0] offsets [128];
        logic [6:0]  numbers [128];
        logic        idle;
        t_out        pending [$];
        int          mismatches;

        function new();
            file_len = 0;
            idle = 1;
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            pos = 0; shreg = 0; size_w = 0; vol_w = 0; sample_sum = 0;
            pcount = 0; pcursor = 0; pcounter = 0;
        endfunction

        function void push(logic v, logic [3:0] rsn, logic [21:0] sz, logic [6:0] pi,
                           logic [6:0] pn, logic k, logic lst);
            t_out r;
            r.kind = k; r.position_index = pi; r.pattern_number = pn;
            r.accepted = v; r.reject_reason = rsn; r.unpacked_size = sz; r.last = lst;
            pending.push_back(r);
        endfunction

        function void reject(logic [3:0] rsn);
            push(1'b0, rsn, '0, '0, '0, KIND_VERDICT, 1'b1);
            idle = 1;
        endfunction

        function void note_request(t_in d);
            logic [9:0]  p;
            logic [9:0]  rel;
            logic [15:0] off;
            logic [6:0]  num, idx;
            logic [16:0] cnt;
            logic [31:0] tot;
            logic        found;
            if (d.first) begin
                clear();
                idle = 0;
            end
            if (idle) return;
            p = pos;
            shreg = {shreg[23:0], d.data_byte};
            pos = pos + 10'd1;
            if (p == ID_END) begin
                if (shreg != ID_WORD) reject(RSN_ID);
            end else if (p == LENGTH_END) begin
                if (shreg == 0 || shreg[0]) reject(RSN_LENGTH);
                else if ({1'b0, shreg} > {1'b0, file_len} + LENGTH_SLACK) reject(RSN_TOO_BIG);
            end else if (p == SAMPLE_PTR_END) begin
                if (shreg == 0 || shreg[0]) reject(RSN_SAMPLE);
            end else if (p >= SAMPLES_AT && p < POS_COUNT_AT) begin
                rel = p - SAMPLES_AT;
                if (rel[2:0] == 1) vol_w = shreg[15:0];
                else if (rel[2:0] == 3) size_w = shreg[15:0];
                else if (rel[2:0] == 7 && (rel >> 3) < N_SAMPLES) begin
                    if (size_w == 0) begin
                        if (shreg[15:0] != REPLEN_EMPTY) reject(RSN_REPLEN);
                    end else if (vol_w > VOLUME_LIMIT) reject(RSN_VOLUME);
                    else sample_sum = sample_sum + {6'd0, size_w, 1'b0};
                end
            end else if (p == POS_COUNT_END) begin
                cnt = {1'b0, shreg[15:0]} + 17'd1;
                if (shreg[15:0] == 16'hffff || cnt > N_POS_MAX) reject(RSN_POS_COUNT);
                else pcount = cnt[7:0];
            end else if (p >= POS_TABLE_AT && p[1:0] == 2'd1) begin
                // p - 0x11c has low bits 01 exactly when p[1:0] == 01
                idx = pcursor[6:0];
                off = shreg[15:0];
                num = 0;
                found = 0;
                for (int j = 0; j < idx; j++)
                    if (!found && offsets[j] == off) begin
                        num = numbers[j];
                        found = 1;
                    end
                if (idx != 0 && !found) begin
                    pcounter = pcounter + 8'd1;
                    num = pcounter[6:0];
                end
                offsets[idx] = off;
                numbers[idx] = num;
                pcursor = pcursor + 8'd1;
                if (pcursor >= pcount) begin
                    push(1'b0, RSN_NONE, '0, idx, num, KIND_POSITION, 1'b0);
                    tot = (32'(pcounter) + 1) * 1024 + 32'(sample_sum) + 32'(BASE_SIZE);
                    if (32'(pcounter) + 1 > N_PAT_MAX) reject(RSN_PATTERNS);
                    else begin
                        if (tot > 32'(SIZE_LIMIT)) tot = 32'(SIZE_LIMIT);
                        push(1'b1, RSN_NONE, tot[21:0], '0, '0, KIND_VERDICT, 1'b1);
                        idle = 1;
                    end
                end else
                    push(1'b0, RSN_NONE, '0, idx, num, KIND_POSITION, 1'b1);
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p got %p", want, got);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [31:0] cfg_data = 0;
    logic        in_valid = 0;
    logic        in_stall;
    t_in         in_req = '0;
    logic        out_valid;
    logic        out_stall = 0;
    t_out        out_res;

    int send_idle = 0, recv_idle = 0;
    int quiet_cycles = 0;
    int byte_count = 0;
    header_scoreboard sb;

    always #4 clk = ~clk;

    packed_module_header_checker_top i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in(in_req),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out(out_res)
    );

    // receiver side: check results, random stall
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) sb.check_result(out_res);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > WATCHDOG) begin
                $display("packed_module_header_checker_top_tb: done, errors");
                $finish;
            end
        end
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    // valid stays high after an accept; the next request or an idle cycle replaces it
    task automatic send_byte(logic [7:0] b, logic f);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_req <= '{data_byte: b, first: f};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request('{data_byte: b, first: f});
        byte_count++;
    endtask

    task automatic write_file_len(logic [31:0] v);
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_we <= 1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
        sb.file_len = v;
    endtask

    // build a module byte image, optionally broken in one place, and send it
    task automatic send_module(t_break brk, int npos, int npat);
        logic [7:0]  img [$];
        logic [31:0] len;
        logic [15:0] vol, sz, rep, cnt_w;
        logic [15:0] offs [128];
        int          total;
        int          stop_at;
        len = {31'($urandom_range(32'h7fff_ffff, 1)), 1'b0};
        if (len > sb.file_len + 256) len = (sb.file_len + 256) & ~32'h1;
        if (len == 0) len = 2;
        if (brk == BRK_LEN_ODD) len = len | 32'd1;
        if (brk == BRK_LEN_ZERO) len = 0;
        if (brk == BRK_LEN_BIG) len = 32'({1'b0, sb.file_len[31:1], 1'b0} + 258);
        img.push_back(8'h4D); img.push_back(8'h45); img.push_back(8'h58);
        img.push_back(brk == BRK_ID ? 8'($urandom_range(8'h57)) : 8'h58);
        for (int i = 0; i < 4; i++) img.push_back(len[31 - 8*i -: 8]);
        for (int i = 8; i < SAMPLE_PTR_BYTE; i++) img.push_back(8'($urandom));
        len = (brk == BRK_SPTR) ? (($urandom_range(1)) ? 32'd0 : ($urandom | 32'd1)) :
              {31'($urandom_range(32'h7fff_ffff, 1)), 1'b0};
        for (int i = 0; i < 4; i++) img.push_back(len[31 - 8*i -: 8]);
        for (int e = 0; e < N_SAMPLES; e++) begin
            sz  = ($urandom_range(3) == 0) ? 16'd0 :
                  ($urandom_range(7) == 0 ? 16'hffff : 16'($urandom));
            vol = 16'($urandom_range(VOLUME_LIMIT));
            rep = (sz == 0) ? REPLEN_EMPTY : 16'($urandom);
            if (e == N_SAMPLES - 1 && brk == BRK_REPLEN) begin
                sz = 0;
                rep = ($urandom_range(1)) ? 16'd0 : 16'($urandom_range(16'hffff, 2));
            end
            if (e == N_SAMPLES - 1 && brk == BRK_VOLUME) begin
                sz = 16'(1 + $urandom_range(16'hfffe));
                vol = 16'($urandom_range(16'hffff, VOLUME_LIMIT + 1));
            end
            img.push_back(vol[15:8]); img.push_back(vol[7:0]);
            img.push_back(sz[15:8]);  img.push_back(sz[7:0]);
            img.push_back(8'($urandom));  img.push_back(8'($urandom));
            img.push_back(rep[15:8]); img.push_back(rep[7:0]);
        end
        cnt_w = 16'(npos - 1);
        if (brk == BRK_COUNT) cnt_w = 16'($urandom_range(16'hfffe, N_POS_MAX));
        if (brk == BRK_COUNT_FFFF) cnt_w = 16'hffff;
        img.push_back(cnt_w[15:8]); img.push_back(cnt_w[7:0]);
        img.push_back(8'($urandom)); img.push_back(8'($urandom));
        for (int i = 0; i < npos; i++) begin
            // mostly reuse offsets from a small pool of npat values
            offs[i] = (i < npat) ? 16'(i * 1024 + $urandom_range(3))
                                 : offs[$urandom_range(i - 1)];
            if ($urandom_range(9) == 0) offs[i] = 16'($urandom);
            img.push_back(offs[i][15:8]); img.push_back(offs[i][7:0]);
            img.push_back(8'($urandom)); img.push_back(8'($urandom));
        end
        total = img.size();
        stop_at = (brk == BRK_TRUNC) ? $urandom_range(total - 1, 1) : total;
        for (int i = 0; i < stop_at; i++) send_byte(img[i], i == 0);
        // trailing noise: ignored while idle, or restarts nothing
        repeat ($urandom_range(3)) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic run_modules(int nbytes);
        t_break brk;
        int     np;
        int     target;
        target = byte_count + nbytes;
        while (byte_count < target) begin
            brk = ($urandom_range(9) < 6) ? BRK_NONE : t_break'($urandom_range(BRK_LAST - 1));
            np = ($urandom_range(7) == 0) ? $urandom_range(N_POS_MAX, 1) : $urandom_range(6, 1);
            if (brk == BRK_PATTERNS) send_module(brk, N_POS_MAX, N_POS_MAX);
            else send_module(brk, np, $urandom_range(np, 1));
        end
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_idle = 13; recv_idle = 47;
        // directed: noise while idle, the early header faults, a full position table
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        write_file_len(32'hffff_ffff);
        for (int b = BRK_ID; b <= BRK_SPTR; b++) send_module(t_break'(b), 2, 2);
        send_module(BRK_PATTERNS, N_POS_MAX, N_POS_MAX);

        send_idle = 47; recv_idle = 13;
        write_file_len(32'($urandom_range(1000)));
        run_modules(300);
        send_idle = 0; recv_idle = 0;
        write_file_len(32'hffff_fffe);
        run_modules(300);

        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("packed_module_header_checker_top_tb: done, clean");
        else
            $display("packed_module_header_checker_top_tb: done, errors");
        $finish;
    end
endmodule
